// ===== hw/rtl/rff_pkg.sv =====
package rff_pkg;

	localparam int CHAN_W        = 8;
	localparam int NUM_CHAN      = 4;
	localparam int PIX_W         = CHAN_W * NUM_CHAN;
	localparam int COEF_W        = 16;
	localparam int FRAC_W        = 12;
	localparam int PROD_W        = 24;
	localparam int TAP_W         = 4;
	localparam int NUM_BANKS     = 3;
	localparam int TAPS_PER_BANK = 4;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 5;
	localparam int REG_IDX_W     = 2;
	localparam int BYTE_MAX      = 255;

	localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1 << (FRAC_W - 1));

	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_0    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_1    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_2    = 2'd3;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
		logic [CHAN_W-1:0] in_alpha;
		logic              row_end;
	} pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              out_row_end;
	} res_t;

	// Load enables of the arithmetic stages, shared by all channel lanes.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ===== hw/rtl/rgba_fir_row_filter_top.sv =====
// Channel  Direction  Handshake               Payload
// pix      in         pix_valid / pix_ready   rff_pkg::pix_t, one RGBA8 pixel and row_end
// res      out        res_valid / res_ready   rff_pkg::res_t, one filtered pixel and row end
// apb      in         psel / penable / pready tap_count at 0x00, coefficient banks at 0x08..0x18
//
// One pixel is taken per clock while no row end is being flushed and the output
// is not stalled. A pixel that ends a row releases F results, F being at most
// (MAX_TAPS+1)/2, and the input pauses while the output job stage steps through
// them. A result passes through the job register, stages s1 to s4 and the output
// register. Reset clears the window, the row position, every pipeline valid bit
// and the registers (one tap, zero coefficients). A stalled output freezes only
// the stages that hold data; empty stages keep filling.
module rgba_fir_row_filter_top #(
	parameter int MAX_TAPS = 12,
	parameter int MAX_ROW  = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  rff_pkg::pix_t                     pix,
	output logic                              res_valid,
	input  logic                              res_ready,
	output rff_pkg::res_t                     res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rff_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [rff_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [rff_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);

	// Widths of the product sums: four taps per partial sum, then the total.
	localparam int GROUPS = (MAX_TAPS + 3) / 4;
	localparam int SUM_W  = rff_pkg::PROD_W + 2 + $clog2(GROUPS);

	logic [rff_pkg::TAP_W-1:0]      tap_count_q;
	logic [rff_pkg::CFG_DATA_W-1:0] bank_q [rff_pkg::NUM_BANKS];
	logic [rff_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           cfg_write;
	logic [rff_pkg::TAP_W-1:0]      taps_eff;

	logic signed [rff_pkg::COEF_W-1:0] coef [MAX_TAPS];

	logic                      valid_s1;
	logic                      last_s1;
	logic [rff_pkg::PIX_W-1:0] px_s1 [MAX_TAPS];
	logic [rff_pkg::CHAN_W-1:0] lane_px [rff_pkg::NUM_CHAN][MAX_TAPS];

	logic                      valid_s2, valid_s3, valid_s4;
	logic                      last_s2, last_s3, last_s4;
	rff_pkg::stage_en_t        en;
	logic                      en_out;
	logic signed [SUM_W-1:0]   lane_sum [rff_pkg::NUM_CHAN];

	// Register file. Writes land on the access phase; reads are combinational.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[rff_pkg::CFG_ADDR_W-1:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= rff_pkg::TAP_W'(1);
			for (int b = 0; b < rff_pkg::NUM_BANKS; b++) bank_q[b] <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				rff_pkg::REG_TAP_COUNT: tap_count_q <= pwdata[rff_pkg::TAP_W-1:0];
				rff_pkg::REG_COEF_0:    bank_q[0]   <= pwdata;
				rff_pkg::REG_COEF_1:    bank_q[1]   <= pwdata;
				rff_pkg::REG_COEF_2:    bank_q[2]   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rff_pkg::REG_TAP_COUNT: prdata = rff_pkg::CFG_DATA_W'(tap_count_q);
			rff_pkg::REG_COEF_0:    prdata = bank_q[0];
			rff_pkg::REG_COEF_1:    prdata = bank_q[1];
			rff_pkg::REG_COEF_2:    prdata = bank_q[2];
			default:                prdata = '0;
		endcase
	end

	// A tap count of zero behaves as one; counts beyond the window saturate.
	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = rff_pkg::TAP_W'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = rff_pkg::TAP_W'(MAX_TAPS);
		end else begin
			taps_eff = tap_count_q;
		end
	end

	// Each bank carries four Q4.12 coefficients, lowest tap in the low bits.
	for (genvar t = 0; t < MAX_TAPS; t++) begin : g_coef
		assign coef[t] = bank_q[t / rff_pkg::TAPS_PER_BANK]
			[rff_pkg::COEF_W*(t % rff_pkg::TAPS_PER_BANK) +: rff_pkg::COEF_W];
	end

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en.s4 = !valid_s4 || en_out;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;

	// Window, row position, output jobs and tap selection.
	rff_seq #(
		.MAX_TAPS (MAX_TAPS),
		.MAX_ROW  (MAX_ROW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.taps      (taps_eff),
		.en2       (en.s2),
		.valid_s1  (valid_s1),
		.last_s1   (last_s1),
		.px_s1     (px_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) last_s2 <= last_s1;
		if (en.s3) last_s3 <= last_s2;
		if (en.s4) last_s4 <= last_s3;
	end

	// One multiply-accumulate lane per color channel, all in lockstep.
	for (genvar c = 0; c < rff_pkg::NUM_CHAN; c++) begin : g_lane
		for (genvar t = 0; t < MAX_TAPS; t++) begin : g_tap
			assign lane_px[c][t] = px_s1[t][rff_pkg::CHAN_W*c +: rff_pkg::CHAN_W];
		end

		rff_lane #(
			.MAX_TAPS (MAX_TAPS),
			.SUM_W    (SUM_W)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.px   (lane_px[c]),
			.coef (coef),
			.sum  (lane_sum[c])
		);
	end

	// Rounding, clamping and the output register.
	rff_merge #(
		.SUM_W (SUM_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (valid_s4),
		.last_s4   (last_s4),
		.sum_s4    (lane_sum),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.en_out    (en_out)
	);

endmodule

// ===== hw/rtl/rff_seq.sv =====
module rff_seq #(
	parameter int MAX_TAPS = 12,
	parameter int MAX_ROW  = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  rff_pkg::pix_t               pix,
	input  logic [rff_pkg::TAP_W-1:0]   taps,
	input  logic                        en2,
	output logic                        valid_s1,
	output logic                        last_s1,
	output logic [rff_pkg::PIX_W-1:0]   px_s1 [MAX_TAPS]
);

	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int POS_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int DW    = $clog2(MAX_TAPS) + 3;

	logic [rff_pkg::PIX_W-1:0] win_q [MAX_TAPS];
	logic [POS_W-1:0]          pos_q;
	logic                      job_v_q;
	logic                      job_flush_q;
	logic                      job_last_q;
	logic [rff_pkg::TAP_W-1:0] job_k_q;
	logic [IDX_W-1:0]          job_n_q;
	logic [rff_pkg::TAP_W-1:0] job_half_q;

	logic [rff_pkg::TAP_W-1:0] half;
	logic [rff_pkg::TAP_W-1:0] maxk;
	logic [rff_pkg::TAP_W-1:0] first;
	logic [IDX_W-1:0]          n_clamp;
	logic                      en1;
	logic                      consume;
	logic                      more;
	logic                      accept;
	logic [rff_pkg::PIX_W-1:0] new_pix;
	logic signed [DW-1:0]      d [MAX_TAPS];
	logic [IDX_W-1:0]          sel [MAX_TAPS];

	assign half    = taps >> 1;
	assign maxk    = taps[0] ? half : half - 1'b1;
	assign first   = (32'(pos_q) < 32'(maxk)) ? rff_pkg::TAP_W'(pos_q) : maxk;
	assign n_clamp = (32'(pos_q) >= 32'(MAX_TAPS - 1)) ? IDX_W'(MAX_TAPS - 1)
	                                                   : IDX_W'(pos_q);
	assign new_pix = {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};

	assign en1       = !valid_s1 || en2;
	assign consume   = job_v_q && en1;
	assign more      = job_flush_q && (job_k_q != '0);
	assign pix_ready = !job_v_q || (consume && !more);
	assign accept    = pix_valid && pix_ready;

	// Pixel window, newest pixel at index zero, and position within the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) win_q[i] <= '0;
			pos_q <= '0;
		end else if (accept) begin
			win_q[0] <= new_pix;
			for (int i = 1; i < MAX_TAPS; i++) win_q[i] <= win_q[i-1];
			if (pix.row_end) begin
				pos_q <= '0;
			end else if (32'(pos_q) < 32'(MAX_ROW - 1)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Output job: position k behind the newest pixel. A row end walks k down to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q     <= 1'b0;
			job_flush_q <= 1'b0;
			job_last_q  <= 1'b0;
			job_k_q     <= '0;
			job_n_q     <= '0;
			job_half_q  <= '0;
		end else if (accept) begin
			job_n_q    <= n_clamp;
			job_half_q <= half;
			if (pix.row_end) begin
				job_v_q     <= 1'b1;
				job_flush_q <= 1'b1;
				job_k_q     <= first;
				job_last_q  <= (first == '0);
			end else begin
				job_v_q     <= (32'(pos_q) >= 32'(maxk));
				job_flush_q <= 1'b0;
				job_k_q     <= maxk;
				job_last_q  <= 1'b0;
			end
		end else if (consume) begin
			if (more) begin
				job_k_q    <= job_k_q - 1'b1;
				job_last_q <= (job_k_q == rff_pkg::TAP_W'(1));
			end else begin
				job_v_q <= 1'b0;
			end
		end
	end

	// Tap addresses, clamped to the edges of the current row.
	always_comb begin
		for (int t = 0; t < MAX_TAPS; t++) begin
			d[t] = DW'(job_k_q) + DW'(job_half_q) - DW'(t);
			if (d[t] < 0) begin
				sel[t] = '0;
			end else if (d[t] > $signed(DW'(job_n_q))) begin
				sel[t] = job_n_q;
			end else begin
				sel[t] = d[t][IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= job_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			last_s1 <= job_last_q;
			for (int t = 0; t < MAX_TAPS; t++) begin
				px_s1[t] <= (t < int'(taps)) ? win_q[sel[t]] : '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_flush_holds_window: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v_q && more) |=> (win_q[0] == $past(win_q[0])))
		else $error("window moved during a row-end flush");

	a_row_end_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix.row_end) |=> (pos_q == '0))
		else $error("row position not cleared after row end");

	a_last_is_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v_q && job_last_q) |-> (job_flush_q && job_k_q == '0))
		else $error("last flag on a job that does not end a flush");

	a_flush_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && more) |=> (job_v_q && job_k_q == $past(job_k_q) - 1'b1))
		else $error("flush did not step to the next position");
`endif

endmodule

// ===== hw/rtl/rff_lane.sv =====
module rff_lane #(
	parameter int MAX_TAPS = 12,
	parameter int SUM_W    = 28
) (
	input  logic                                clk,
	input  rff_pkg::stage_en_t                  en,
	input  logic [rff_pkg::CHAN_W-1:0]          px [MAX_TAPS],
	input  logic signed [rff_pkg::COEF_W-1:0]   coef [MAX_TAPS],
	output logic signed [SUM_W-1:0]             sum
);

	localparam int GROUPS = (MAX_TAPS + 3) / 4;
	localparam int PS_W   = rff_pkg::PROD_W + 2;
	localparam int FULL_W = rff_pkg::COEF_W + rff_pkg::CHAN_W + 1;

	logic signed [rff_pkg::PROD_W-1:0] prod_s2 [MAX_TAPS];
	logic signed [PS_W-1:0]            psum_s3 [GROUPS];
	logic signed [SUM_W-1:0]           sum_s4;

	logic signed [FULL_W-1:0]          full [MAX_TAPS];
	logic signed [PS_W-1:0]            grp [GROUPS];
	logic signed [SUM_W-1:0]           total;

	always_comb begin
		for (int t = 0; t < MAX_TAPS; t++) begin
			full[t] = coef[t] * $signed({1'b0, px[t]});
		end
	end

	// Partial sums over groups of four taps.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp[g] = '0;
			for (int i = 0; i < 4; i++) begin
				if (g * 4 + i < MAX_TAPS) grp[g] = grp[g] + PS_W'(prod_s2[g*4+i]);
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GROUPS; g++) total = total + SUM_W'(psum_s3[g]);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int t = 0; t < MAX_TAPS; t++) prod_s2[t] <= full[t][rff_pkg::PROD_W-1:0];
		end
		if (en.s3) begin
			for (int g = 0; g < GROUPS; g++) psum_s3[g] <= grp[g];
		end
		if (en.s4) begin
			sum_s4 <= total;
		end
	end

	assign sum = sum_s4;

endmodule

// ===== hw/rtl/rff_merge.sv =====
module rff_merge #(
	parameter int SUM_W = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s4,
	input  logic                    last_s4,
	input  logic signed [SUM_W-1:0] sum_s4 [rff_pkg::NUM_CHAN],
	output logic                    res_valid,
	input  logic                    res_ready,
	output rff_pkg::res_t           res,
	output logic                    en_out
);

	localparam int Q_W = SUM_W - rff_pkg::FRAC_W;

	rff_pkg::res_t res_q;
	logic          res_valid_q;

	// Round to nearest, ties to even, then clamp to a byte.
	function automatic logic [rff_pkg::CHAN_W-1:0] round_clamp(
		input logic signed [SUM_W-1:0] s
	);
		logic [Q_W-1:0]            q;
		logic [rff_pkg::FRAC_W-1:0] f;
		logic                      up;
		logic [Q_W:0]              qr;
		logic [rff_pkg::CHAN_W-1:0] r;
		q  = s[SUM_W-1:rff_pkg::FRAC_W];
		f  = s[rff_pkg::FRAC_W-1:0];
		up = (f > rff_pkg::ROUND_HALF) || ((f == rff_pkg::ROUND_HALF) && q[0]);
		qr = {1'b0, q} + (Q_W + 1)'(up);
		if (s <= 0) begin
			r = '0;
		end else if (qr > (Q_W + 1)'(rff_pkg::BYTE_MAX)) begin
			r = rff_pkg::CHAN_W'(rff_pkg::BYTE_MAX);
		end else begin
			r = qr[rff_pkg::CHAN_W-1:0];
		end
		return r;
	endfunction

	assign en_out = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s4) begin
			res_q.out_red     <= round_clamp(sum_s4[0]);
			res_q.out_green   <= round_clamp(sum_s4[1]);
			res_q.out_blue    <= round_clamp(sum_s4[2]);
			res_q.out_alpha   <= round_clamp(sum_s4[3]);
			res_q.out_row_end <= last_s4;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== test/rgba_fir_row_checker.sv =====
`timescale 1ns / 100ps

module rgba_fir_row_checker import rff_pkg::*; #(
	parameter int MAX_TAPS = 12,
	parameter int MAX_ROW  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_ready,
	input  pix_t                  pix,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  res_t                  res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    errors,
	output int                    waiting
);

	logic [TAP_W-1:0]      tap_reg;
	logic [CFG_DATA_W-1:0] coef_bank [NUM_BANKS];
	logic [PIX_W-1:0]      line_window [MAX_TAPS];
	int                    row_pos;
	int                    fail_count;
	res_t                  filtered_due [$];

	function automatic longint coef_at(input int t);
		logic [COEF_W-1:0] w;
		w = coef_bank[t / TAPS_PER_BANK][COEF_W * (t % TAPS_PER_BANK) +: COEF_W];
		return longint'($signed(w));
	endfunction

	// Round to nearest with ties to even, then clamp to a byte.
	function automatic logic [CHAN_W-1:0] round_sat(input longint acc);
		longint            q;
		logic [FRAC_W-1:0] f;
		if (acc <= 0)
			return '0;
		q = acc >>> FRAC_W;
		f = acc[FRAC_W-1:0];
		if (f > ROUND_HALF || (f == ROUND_HALF && q[0]))
			q++;
		return (q > BYTE_MAX) ? CHAN_W'(BYTE_MAX) : CHAN_W'(q);
	endfunction

	// Filtered pixel k positions behind the newest one, n being its row index.
	// Every tap is clamped to the current row, so older rows are never read.
	function automatic res_t filtered_pixel(input int k, input int n, input int taps,
			input int half, input bit last);
		longint           acc [NUM_CHAN];
		logic [PIX_W-1:0] px;
		res_t             r;
		int               d;
		int               t;
		int               c;
		for (c = 0; c < NUM_CHAN; c++)
			acc[c] = 0;
		for (t = 0; t < taps; t++) begin
			d = k - (t - half);
			if (d < 0)
				d = 0;
			if (d > n)
				d = n;
			if (d > MAX_TAPS - 1)
				d = MAX_TAPS - 1;
			px = line_window[d];
			for (c = 0; c < NUM_CHAN; c++)
				acc[c] += coef_at(t) * longint'(px[CHAN_W * c +: CHAN_W]);
		end
		r.out_red     = round_sat(acc[0]);
		r.out_green   = round_sat(acc[1]);
		r.out_blue    = round_sat(acc[2]);
		r.out_alpha   = round_sat(acc[3]);
		r.out_row_end = last;
		return r;
	endfunction

	task automatic compare_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int   taps;
		int   half;
		int   reach;
		int   n;
		int   k;
		int   i;
		res_t want;
		if (!arst_n) begin
			tap_reg = TAP_W'(1);
			for (i = 0; i < NUM_BANKS; i++)
				coef_bank[i] = '0;
			for (i = 0; i < MAX_TAPS; i++)
				line_window[i] = '0;
			row_pos = 0;
			fail_count = 0;
			filtered_due.delete();
			errors <= 0;
			waiting <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_W-1:3])
					REG_TAP_COUNT: tap_reg = pwdata[TAP_W-1:0];
					REG_COEF_0:    coef_bank[0] = pwdata;
					REG_COEF_1:    coef_bank[1] = pwdata;
					REG_COEF_2:    coef_bank[2] = pwdata;
					default:       ;
				endcase
			end

			if (pix_valid && pix_ready) begin
				if (tap_reg == 0)
					taps = 1;
				else if (int'(tap_reg) > MAX_TAPS)
					taps = MAX_TAPS;
				else
					taps = int'(tap_reg);
				half = taps / 2;
				reach = (taps % 2 == 0) ? half - 1 : half;
				n = row_pos;
				for (i = MAX_TAPS - 1; i > 0; i--)
					line_window[i] = line_window[i - 1];
				line_window[0] = {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};
				if (pix.row_end) begin
					for (k = (reach < n) ? reach : n; k >= 0; k--)
						filtered_due.push_back(filtered_pixel(k, n, taps, half, k == 0));
					row_pos = 0;
				end else begin
					if (n >= reach)
						filtered_due.push_back(filtered_pixel(reach, n, taps, half, 1'b0));
					if (row_pos < MAX_ROW - 1)
						row_pos++;
				end
			end

			if (res_valid && res_ready) begin
				if (filtered_due.size() == 0) begin
					fail_count++;
					$display("%0t: expected no result, got %p", $time, res);
				end else begin
					want = filtered_due.pop_front();
					compare_field("out_red", want.out_red, res.out_red);
					compare_field("out_green", want.out_green, res.out_green);
					compare_field("out_blue", want.out_blue, res.out_blue);
					compare_field("out_alpha", want.out_alpha, res.out_alpha);
					compare_field("out_row_end", want.out_row_end, res.out_row_end);
				end
			end

			errors <= fail_count;
			waiting <= filtered_due.size();
		end
	end

endmodule

// ===== test/tb_rgba_fir_row_filter_top.sv =====
`timescale 1ns / 100ps

module tb_rgba_fir_row_filter_top;

	import rff_pkg::*;

	localparam int TAP_LIMIT   = 12;
	localparam int ROW_LIMIT   = 32;
	// Pipeline latency plus the longest row-end flush, with some margin.
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 40000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_ready;
	pix_t                  pix;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int errors;
	int waiting;
	int cycle_count = 0;

	// Requests from the stimulus process to the result sink. Both are driven
	// with nonblocking assignments.
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rgba_fir_row_filter_top #(
		.MAX_TAPS(TAP_LIMIT),
		.MAX_ROW (ROW_LIMIT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rgba_fir_row_checker #(
		.MAX_TAPS(TAP_LIMIT),
		.MAX_ROW (ROW_LIMIT)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.waiting  (waiting)
	);

	// A hung handshake or a result that never shows up ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_rgba_fir_row_filter_top: errors");
			$finish;
		end
	end

	// Result sink. It stalls in about a fifth of the cycles, never while the
	// calm flag is up, and once goes deaf for a long stretch so that the
	// pipeline fills and the pixel input has to stall.
	initial begin : result_sink
		bit held;
		held = 1'b0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ready <= calm || ($urandom_range(99) >= 21);
		end
	end

	function automatic pix_t make_pix(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input logic last);
		pix_t p;
		p.in_red   = r;
		p.in_green = g;
		p.in_blue  = b;
		p.in_alpha = a;
		p.row_end  = last;
		return p;
	endfunction

	// Four coefficients for one bank. Half are small so that sums stay inside
	// the byte range; the rest are unity, the Q4.12 extremes or anything.
	function automatic logic [CFG_DATA_W-1:0] random_bank();
		logic [CFG_DATA_W-1:0] bank;
		int                    j;
		for (j = 0; j < TAPS_PER_BANK; j++) begin
			case ($urandom_range(5))
				0:       bank[COEF_W * j +: COEF_W] = 16'h1000;
				1:       bank[COEF_W * j +: COEF_W] = COEF_W'($urandom);
				2:       bank[COEF_W * j +: COEF_W] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				default: bank[COEF_W * j +: COEF_W] = COEF_W'($urandom_range(1536)) - COEF_W'(512);
			endcase
		end
		return bank;
	endfunction

	// One pixel transfer. The valid line drops only for idle cycles, so a
	// back-to-back pixel keeps it high without a glitch.
	task automatic send_pixel(input pix_t p);
		while (!calm && $urandom_range(99) < 21) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
	endtask

	// A row of random pixels; row_end goes on the last one only if closed.
	task automatic send_row(input int len, input bit closed);
		pix_t p;
		int   i;
		for (i = 0; i < len; i++) begin
			p.in_red   = 8'($urandom);
			p.in_green = 8'($urandom);
			p.in_blue  = 8'($urandom);
			p.in_alpha = 8'($urandom);
			p.row_end  = closed && (i == len - 1);
			send_pixel(p);
		end
	endtask

	// Drop valid and wait until every predicted pixel has come out. The first
	// edge lets the checker count the transfer that just happened; the settle
	// time covers a pixel that left nothing in the queue but is still in flight.
	task automatic wait_drained();
		pix_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready. A spare cycle at the
	// end keeps back-to-back writes from reassigning psel in one time step.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_kernel(input logic [TAP_W-1:0] taps, input logic [CFG_DATA_W-1:0] b0,
			input logic [CFG_DATA_W-1:0] b1, input logic [CFG_DATA_W-1:0] b2);
		apb_write(REG_TAP_COUNT, CFG_DATA_W'(taps));
		apb_write(REG_COEF_0, b0);
		apb_write(REG_COEF_1, b1);
		apb_write(REG_COEF_2, b2);
	endtask

	// Random rows, mostly short, sometimes long enough to fill the window.
	// The last row of a phase is occasionally left open, so the next kernel
	// takes over in the middle of a row.
	task automatic run_rows(input int quota);
		int sent;
		int len;
		sent = 0;
		while (sent < quota) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
			send_row(len, (sent + len < quota) || ($urandom_range(3) != 0));
			sent += len;
		end
	endtask

	initial begin : stimulus
		int phase;
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pix <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset kernel: one tap of zero, so everything filters to black.
		send_pixel(make_pix(8'hFF, 8'h00, 8'hA5, 8'h5A, 1'b0));
		send_pixel(make_pix(8'h00, 8'hFF, 8'h5A, 8'hA5, 1'b1));
		wait_drained();

		// A single half-weight tap puts every odd byte on a rounding tie, so
		// both directions of ties-to-even show up.
		load_kernel(TAP_W'(1), 64'h0000_0000_0000_0800, '0, '0);
		send_pixel(make_pix(8'd1, 8'd3, 8'd255, 8'd0, 1'b1));
		send_pixel(make_pix(8'd2, 8'd5, 8'd254, 8'd129, 1'b0));
		send_pixel(make_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(make_pix(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		wait_drained();

		// Widest kernel at the largest positive weight: sums saturate high.
		// Rows shorter than the kernel exercise the edge clamping.
		load_kernel(TAP_W'(TAP_LIMIT), {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
		send_row(1, 1'b1);
		send_row(3, 1'b1);
		send_row(7, 1'b1);
		wait_drained();

		// A tap count above the maximum acts as the maximum; the most negative
		// weight drives every sum below zero.
		load_kernel(TAP_W'(15), {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
		send_row(3, 1'b1);
		wait_drained();

		// A tap count of zero acts as one: unity in tap 0, the rest unused.
		load_kernel(TAP_W'(0), {48'h8000_7FFF_1234, 16'h1000}, random_bank(), random_bank());
		send_row(2, 1'b1);
		wait_drained();

		for (phase = 0; phase < 9; phase++) begin
			load_kernel(TAP_W'(($urandom_range(4) == 0) ? $urandom_range(15)
					: $urandom_range(TAP_LIMIT, 1)), random_bank(), random_bank(), random_bank());
			calm <= (phase == 2);
			hold_req <= (phase == 5);
			run_rows(40);
			wait_drained();
		end
		calm <= 1'b0;

		// One row longer than the position counter can track.
		load_kernel(TAP_W'($urandom_range(TAP_LIMIT, 1)), random_bank(), random_bank(),
				random_bank());
		send_row(ROW_LIMIT + 24, 1'b1);
		wait_drained();

		if (errors == 0)
			$display("tb_rgba_fir_row_filter_top: clean");
		else
			$display("tb_rgba_fir_row_filter_top: errors");
		$finish;
	end

endmodule
